// ===== src/fses_pkg.sv =====
`timescale 1ns / 1ps

package fses_pkg;

	// Request kinds carried on tuser.
	typedef enum logic {
		CMD_SPREAD = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	localparam int HEAT_W = 6;
	localparam logic [HEAT_W-1:0] HEAT_MAX = 6'd36;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	// Fire palette, black through red and yellow to white. Heat above the top
	// entry saturates to white.
	function automatic rgb_t palette(input logic [HEAT_W-1:0] heat);
		rgb_t c;
		unique case (heat)
			6'd0:  c = '{blue: 8'h07, green: 8'h07, red: 8'h07};
			6'd1:  c = '{blue: 8'h07, green: 8'h07, red: 8'h1F};
			6'd2:  c = '{blue: 8'h07, green: 8'h0F, red: 8'h2F};
			6'd3:  c = '{blue: 8'h07, green: 8'h0F, red: 8'h47};
			6'd4:  c = '{blue: 8'h07, green: 8'h17, red: 8'h57};
			6'd5:  c = '{blue: 8'h07, green: 8'h1F, red: 8'h67};
			6'd6:  c = '{blue: 8'h07, green: 8'h1F, red: 8'h77};
			6'd7:  c = '{blue: 8'h07, green: 8'h27, red: 8'h8F};
			6'd8:  c = '{blue: 8'h07, green: 8'h2F, red: 8'h9F};
			6'd9:  c = '{blue: 8'h07, green: 8'h3F, red: 8'hAF};
			6'd10: c = '{blue: 8'h07, green: 8'h47, red: 8'hBF};
			6'd11: c = '{blue: 8'h07, green: 8'h47, red: 8'hC7};
			6'd12: c = '{blue: 8'h07, green: 8'h4F, red: 8'hDF};
			6'd13: c = '{blue: 8'h07, green: 8'h57, red: 8'hDF};
			6'd14: c = '{blue: 8'h07, green: 8'h57, red: 8'hDF};
			6'd15: c = '{blue: 8'h07, green: 8'h5F, red: 8'hD7};
			6'd16: c = '{blue: 8'h07, green: 8'h5F, red: 8'hD7};
			6'd17: c = '{blue: 8'h0F, green: 8'h67, red: 8'hD7};
			6'd18: c = '{blue: 8'h0F, green: 8'h6F, red: 8'hCF};
			6'd19: c = '{blue: 8'h0F, green: 8'h77, red: 8'hCF};
			6'd20: c = '{blue: 8'h0F, green: 8'h7F, red: 8'hCF};
			6'd21: c = '{blue: 8'h17, green: 8'h87, red: 8'hCF};
			6'd22: c = '{blue: 8'h17, green: 8'h87, red: 8'hC7};
			6'd23: c = '{blue: 8'h17, green: 8'h8F, red: 8'hC7};
			6'd24: c = '{blue: 8'h1F, green: 8'h97, red: 8'hC7};
			6'd25: c = '{blue: 8'h1F, green: 8'h9F, red: 8'hBF};
			6'd26: c = '{blue: 8'h1F, green: 8'h9F, red: 8'hBF};
			6'd27: c = '{blue: 8'h27, green: 8'hA7, red: 8'hBF};
			6'd28: c = '{blue: 8'h27, green: 8'hA7, red: 8'hBF};
			6'd29: c = '{blue: 8'h2F, green: 8'hAF, red: 8'hBF};
			6'd30: c = '{blue: 8'h2F, green: 8'hAF, red: 8'hB7};
			6'd31: c = '{blue: 8'h2F, green: 8'hB7, red: 8'hB7};
			6'd32: c = '{blue: 8'h37, green: 8'hB7, red: 8'hB7};
			6'd33: c = '{blue: 8'h6F, green: 8'hCF, red: 8'hCF};
			6'd34: c = '{blue: 8'h9F, green: 8'hDF, red: 8'hDF};
			6'd35: c = '{blue: 8'hC7, green: 8'hEF, red: 8'hEF};
			default: c = '{blue: 8'hFF, green: 8'hFF, red: 8'hFF};
		endcase
		return c;
	endfunction

endpackage

// ===== src/fses_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
// A read and a write to the same address in one cycle return the old data.
module fses_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Storage array and read register.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/fire_effect_spread_engine_top.sv =====
// An accepted request passes through stage 1, stage 2 and the result register to m_axis.
// Throughput: one request per cycle unless m_axis_tready stalls; the single heat RAM port
// pair (one read, one write) sets that figure, with a one-entry bypass covering a read
// that meets a pending write. Reset: arst_n clears all control state, then a clearing
// pass over all GRID_WIDTH * GRID_HEIGHT cells writes the heat RAM (bottom row hot, the
// rest cold) while s_axis_tready stays low.
`timescale 1ns / 1ps

module fire_effect_spread_engine_top
	import fses_pkg::*;
#(
	parameter int GRID_WIDTH  = 320,
	parameter int GRID_HEIGHT = 168
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// random_bits [1:0], read_column [10:2], read_row [18:11], zero [23:19]
	input  logic [23:0] s_axis_tdata,
	// command [0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// written_index [15:0], written_heat [21:16], cell_heat [27:22],
	// colour_red [35:28], colour_green [43:36], colour_blue [51:44], zero [55:52]
	output logic [55:0] m_axis_tdata,
	// kind [0]
	output logic        m_axis_tuser,
	// frame_done
	output logic        m_axis_tlast
);

	localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int RW         = (ADDR_W > 9) ? ADDR_W : 9;

	localparam logic [ADDR_W-1:0] WIDTH_A  = ADDR_W'(GRID_WIDTH);
	localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] BOTTOM_A = ADDR_W'(CELL_COUNT - GRID_WIDTH);
	localparam logic [RW-1:0]     WIDTH_R  = RW'(GRID_WIDTH);
	localparam logic [RW-1:0]     HEIGHT_R = RW'(GRID_HEIGHT);

	// Clearing pass state.
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Scan position.
	logic [ADDR_W-1:0] scan_q;

	// Stage 1: registered request.
	logic              s1_v;
	cmd_t              cmd_s1;
	logic [1:0]        rnd_s1;
	logic [8:0]        col_s1;
	logic [7:0]        row_s1;
	logic [ADDR_W-1:0] scan_s1;
	logic              last_s1;

	// Stage 2: RAM data available.
	logic              s2_v;
	cmd_t              cmd_s2;
	logic [1:0]        rnd_s2;
	logic [ADDR_W-1:0] scan_s2;
	logic              last_s2;
	logic              byp_s2;
	logic [HEAT_W-1:0] bypd_s2;

	// Result register.
	logic              out_valid_q;
	cmd_t              kind_q;
	logic [15:0]       widx_q;
	logic [HEAT_W-1:0] wheat_q;
	logic              last_q;
	logic [HEAT_W-1:0] cheat_q;
	rgb_t              rgb_q;

	logic              in_acc;
	logic              out_free;
	logic              s2_ready;
	logic              s1_go;
	logic              out_go;
	logic [RW-1:0]     col_sat;
	logic [RW-1:0]     row_sat;
	logic [RW-1:0]     read_lin;
	logic [ADDR_W-1:0] rd_addr;
	logic [HEAT_W-1:0] ram_q;
	logic [HEAT_W-1:0] heat_s2;
	logic [ADDR_W:0]   dest_lin;
	logic [ADDR_W-1:0] dst;
	logic [HEAT_W-1:0] val;
	logic              spread_wr;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_wa;
	logic [HEAT_W-1:0] ram_wd;

	// Handshake and stage advance.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s2_ready      = !s2_v || out_free;
	assign s1_go         = s1_v && s2_ready;
	assign out_go        = s2_v && out_free;
	assign s_axis_tready = !clr_busy_q && (!s1_v || s2_ready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Clearing pass after reset, one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == LAST_A) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Scan position advances on every spread request and wraps to row one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= WIDTH_A;
		end else if (in_acc && cmd_t'(s_axis_tuser) == CMD_SPREAD) begin
			scan_q <= (scan_q == LAST_A) ? WIDTH_A : scan_q + 1'b1;
		end
	end

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_acc) begin
			s1_v <= 1'b1;
		end else if (s1_go) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			rnd_s1  <= s_axis_tdata[1:0];
			col_s1  <= s_axis_tdata[10:2];
			row_s1  <= s_axis_tdata[18:11];
			scan_s1 <= scan_q;
			last_s1 <= (scan_q == LAST_A);
		end
	end

	// Read address: the scan cell, or the saturated read coordinates.
	always_comb begin
		col_sat  = (RW'(col_s1) >= WIDTH_R) ? WIDTH_R - 1'b1 : RW'(col_s1);
		row_sat  = (RW'(row_s1) >= HEIGHT_R) ? HEIGHT_R - 1'b1 : RW'(row_s1);
		read_lin = row_sat * WIDTH_R + col_sat;
		rd_addr  = (cmd_s1 == CMD_READ) ? ADDR_W'(read_lin) : scan_s1;
	end

	// Stage 2 registers, with bypass of a write that lands on the same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s1_go) begin
			s2_v <= 1'b1;
		end else if (out_go) begin
			s2_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			cmd_s2  <= cmd_s1;
			rnd_s2  <= rnd_s1;
			scan_s2 <= scan_s1;
			last_s2 <= last_s1;
			byp_s2  <= spread_wr && (dst == rd_addr);
			bypd_s2 <= val;
		end
	end

	assign heat_s2 = byp_s2 ? bypd_s2 : ram_q;

	// Spread rule: cold cells clear the cell above; hot cells drift by (1 - random) and cool by random bit 0.
	always_comb begin
		dest_lin = {1'b0, scan_s2} + 1'b1 - {{(ADDR_W - 1){1'b0}}, rnd_s2};
		if (heat_s2 == '0) begin
			dst = scan_s2 - WIDTH_A;
			val = '0;
		end else begin
			if (dest_lin < {1'b0, WIDTH_A}) begin
				dst = scan_s2 - WIDTH_A;
			end else begin
				dst = ADDR_W'(dest_lin - {1'b0, WIDTH_A});
			end
			val = heat_s2 - HEAT_W'(rnd_s2[0]);
		end
	end

	assign spread_wr = out_go && cmd_s2 == CMD_SPREAD;

	// RAM write port: clearing pass first, then spread writes.
	always_comb begin
		if (clr_busy_q) begin
			ram_we = 1'b1;
			ram_wa = clr_addr_q;
			ram_wd = (clr_addr_q >= BOTTOM_A) ? HEAT_MAX : '0;
		end else begin
			ram_we = spread_wr;
			ram_wa = dst;
			ram_wd = val;
		end
	end

	fses_ram #(
		.WIDTH (HEAT_W),
		.DEPTH (CELL_COUNT)
	) u_heat_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_en   (s1_go),
		.rd_addr (rd_addr),
		.rd_data (ram_q)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_go) begin
			kind_q <= cmd_s2;
			if (cmd_s2 == CMD_SPREAD) begin
				widx_q  <= 16'(dst);
				wheat_q <= val;
				last_q  <= last_s2;
				cheat_q <= '0;
				rgb_q   <= '0;
			end else begin
				widx_q  <= '0;
				wheat_q <= '0;
				last_q  <= 1'b0;
				cheat_q <= heat_s2;
				rgb_q   <= palette(heat_s2);
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {4'b0, rgb_q.blue, rgb_q.green, rgb_q.red, cheat_q, wheat_q, widx_q};

endmodule
